FILE: rtl/smf_pkg.sv
// ----------------------------------------------------------------------------
// smf_pkg
// Shared types, constants and lookup functions of the sensor message framer.
// ----------------------------------------------------------------------------
`default_nettype none

package smf_pkg;

  // Message kinds carried on the input tuser
  typedef enum logic [1:0] {
    KIND_MOTION  = 2'd0,
    KIND_COMPASS = 2'd1,
    KIND_ENV     = 2'd2,
    KIND_UNKNOWN = 2'd3
  } kind_t;

  // Frame constants
  localparam logic [7:0]  START_BYTE  = 8'h01;
  localparam logic [7:0]  ID_MOTION   = 8'h10;
  localparam logic [7:0]  ID_COMPASS  = 8'h11;
  localparam logic [7:0]  ID_ENV      = 8'h12;
  localparam logic [15:0] LEN_MOTION  = 16'(3 * 3 * 4);
  localparam logic [15:0] LEN_COMPASS = 16'(4 * 4 + 1);
  localparam logic [15:0] LEN_ENV     = 16'(3 * 4);

  localparam int NUM_WORDS   = 9;
  localparam int WORD_BITS   = 32;
  localparam int MSG_BITS    = NUM_WORDS * WORD_BITS;
  localparam int CNT_BITS    = 6;

  // Byte source picked by one microcode step
  typedef enum logic [2:0] {
    SEL_START   = 3'd0,
    SEL_ID      = 3'd1,
    SEL_LEN_HI  = 3'd2,
    SEL_LEN_LO  = 3'd3,
    SEL_PAYLOAD = 3'd4,
    SEL_STATUS  = 3'd5,
    SEL_SUM     = 3'd6
  } byte_sel_t;

  // Step counter of the microprogram
  typedef logic [2:0] pc_t;

  // One control word of the microprogram
  typedef struct packed {
    byte_sel_t sel;
    logic      loop;   // repeat step until the word byte count runs out
    logic      skip;   // on leaving, jump over the next step unless compass
    logic      last;   // closing byte of the frame
  } ucode_t;

  // Control from the sequencer to the datapath
  typedef struct packed {
    logic      busy;
    logic      emit;
    byte_sel_t sel;
    logic      last;
    kind_t     kind;
  } dp_ctl_t;

  // Frame id per kind
  function automatic logic [7:0] kind_id(kind_t kind);
    logic [7:0] id;
    unique case (kind)
      KIND_MOTION:  id = ID_MOTION;
      KIND_COMPASS: id = ID_COMPASS;
      KIND_ENV:     id = ID_ENV;
      default:      id = ID_ENV;
    endcase
    return id;
  endfunction

  // Payload length per kind
  function automatic logic [15:0] frame_len(kind_t kind);
    logic [15:0] len;
    unique case (kind)
      KIND_MOTION:  len = LEN_MOTION;
      KIND_COMPASS: len = LEN_COMPASS;
      KIND_ENV:     len = LEN_ENV;
      default:      len = LEN_ENV;
    endcase
    return len;
  endfunction

  // Index of the last word byte (status byte excluded)
  function automatic logic [CNT_BITS-1:0] last_word_byte(kind_t kind);
    logic [CNT_BITS-1:0] n;
    unique case (kind)
      KIND_MOTION:  n = CNT_BITS'(3 * 3 * 4 - 1);
      KIND_COMPASS: n = CNT_BITS'(4 * 4 - 1);
      KIND_ENV:     n = CNT_BITS'(3 * 4 - 1);
      default:      n = CNT_BITS'(3 * 4 - 1);
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/sensor_message_framer.sv
// ----------------------------------------------------------------------------
// sensor_message_framer
// Frames one sensor message as start, id, length, payload and checksum bytes.
// ----------------------------------------------------------------------------
// The message beat sets the sequencer busy; the start byte is then registered.
// Throughput: one frame byte per cycle unless the output stalls; a frame holds
//   41 (motion), 22 (compass) or 17 (environment) bytes, set by the microcode
//   loop over the payload bytes. The next message is taken on the checksum cycle.
// An unknown kind is taken and emits nothing. Output stalls hold
//   the sequencer. Reset (rst_n low, synchronous) idles the sequencer.
`default_nettype none

module sensor_message_framer (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // word0..word8 [287:0] (word0 lowest), heading_status [295:288]
  input  wire logic [295:0] in_tdata,
  // req_type [1:0]
  input  wire logic [1:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // frame_byte [7:0]
  output logic [7:0]        out_tdata,
  output logic              out_tlast
);

  logic             load;
  logic             out_free;
  smf_pkg::dp_ctl_t ctl;

  assign load = in_tvalid & in_tready;

  smf_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .load_kind (in_tuser),
    .out_free  (out_free),
    .ready     (in_tready),
    .ctl       (ctl)
  );

  smf_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (load),
    .load_words  (in_tdata[smf_pkg::MSG_BITS-1:0]),
    .load_status (in_tdata[smf_pkg::MSG_BITS+7:smf_pkg::MSG_BITS]),
    .ctl         (ctl),
    .out_free    (out_free),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_byte    (out_tdata),
    .out_last    (out_tlast)
  );

  // A known message starts the program at the start byte
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    load && in_tuser != smf_pkg::KIND_UNKNOWN |=>
      ctl.busy && ctl.sel == smf_pkg::SEL_START)
    else $error("known message did not start at start byte");

  // An unknown message taken while idle leaves the block idle
  a_unknown: assert property (@(posedge clk) disable iff (!rst_n)
    load && !ctl.busy && in_tuser == smf_pkg::KIND_UNKNOWN |=> !ctl.busy)
    else $error("unknown message started a frame");

  // Only the checksum step closes a frame
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit && ctl.last |-> ctl.sel == smf_pkg::SEL_SUM)
    else $error("frame closed on a non-checksum byte");

  // No byte is emitted while the output register is held
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !ctl.emit)
    else $error("byte emitted into a stalled output register");

endmodule

`default_nettype wire

FILE: rtl/smf_seq.sv
// ----------------------------------------------------------------------------
// smf_seq
// Microcode sequencer: step counter, control ROM, byte loop counter and
// conditional jump over the compass status step.
// ----------------------------------------------------------------------------
`default_nettype none

module smf_seq (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           load,       // message beat accepted
  input  wire logic [1:0]     load_kind,
  input  wire logic           out_free,   // output register can take a byte
  output logic                ready,
  output smf_pkg::dp_ctl_t    ctl
);

  logic                              busy_r, busy_nxt;
  smf_pkg::pc_t                      pc_r, pc_nxt;
  logic [smf_pkg::CNT_BITS-1:0]      cnt_r, cnt_nxt;
  smf_pkg::kind_t                    kind_r, kind_nxt;
  smf_pkg::ucode_t                   uw;
  logic                              fire;
  logic                              cnt_end;
  logic                              known;

  // Control ROM
  always_comb begin
    unique case (pc_r)
      3'd0:    uw = '{sel: smf_pkg::SEL_START,   loop: 1'b0, skip: 1'b0, last: 1'b0};
      3'd1:    uw = '{sel: smf_pkg::SEL_ID,      loop: 1'b0, skip: 1'b0, last: 1'b0};
      3'd2:    uw = '{sel: smf_pkg::SEL_LEN_HI,  loop: 1'b0, skip: 1'b0, last: 1'b0};
      3'd3:    uw = '{sel: smf_pkg::SEL_LEN_LO,  loop: 1'b0, skip: 1'b0, last: 1'b0};
      3'd4:    uw = '{sel: smf_pkg::SEL_PAYLOAD, loop: 1'b1, skip: 1'b1, last: 1'b0};
      3'd5:    uw = '{sel: smf_pkg::SEL_STATUS,  loop: 1'b0, skip: 1'b0, last: 1'b0};
      3'd6:    uw = '{sel: smf_pkg::SEL_SUM,     loop: 1'b0, skip: 1'b0, last: 1'b1};
      default: uw = '{sel: smf_pkg::SEL_SUM,     loop: 1'b0, skip: 1'b0, last: 1'b1};
    endcase
  end

  assign fire    = busy_r & out_free;
  assign cnt_end = (cnt_r == smf_pkg::last_word_byte(kind_r));
  assign known   = (smf_pkg::kind_t'(load_kind) != smf_pkg::KIND_UNKNOWN);
  assign ready   = ~busy_r | (fire & uw.last);

  // Next step
  always_comb begin
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    cnt_nxt  = cnt_r;
    kind_nxt = kind_r;
    if (fire) begin
      if (uw.loop && !cnt_end) begin
        cnt_nxt = cnt_r + 1'b1;
      end else if (uw.skip && kind_r != smf_pkg::KIND_COMPASS) begin
        pc_nxt = pc_r + 3'd2;
      end else begin
        pc_nxt = pc_r + 3'd1;
      end
      if (uw.last) begin
        busy_nxt = 1'b0;
      end
    end
    if (load) begin
      busy_nxt = known;
      pc_nxt   = '0;
      cnt_nxt  = '0;
      kind_nxt = smf_pkg::kind_t'(load_kind);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= '0;
      cnt_r  <= '0;
      kind_r <= smf_pkg::KIND_MOTION;
    end else begin
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
      cnt_r  <= cnt_nxt;
      kind_r <= kind_nxt;
    end
  end

  assign ctl.busy = busy_r;
  assign ctl.emit = fire;
  assign ctl.sel  = uw.sel;
  assign ctl.last = uw.last;
  assign ctl.kind = kind_r;

endmodule

`default_nettype wire

FILE: rtl/smf_datapath.sv
// ----------------------------------------------------------------------------
// smf_datapath
// Message shift register, byte select, running checksum and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module smf_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          load,
  input  wire logic [smf_pkg::MSG_BITS-1:0]  load_words,
  input  wire logic [7:0]                    load_status,
  input  wire smf_pkg::dp_ctl_t              ctl,
  output logic                               out_free,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [7:0]                         out_byte,
  output logic                               out_last
);

  logic [smf_pkg::MSG_BITS-1:0] msg_r;
  logic [7:0]                   status_r;
  logic [7:0]                   sum_r;
  logic [7:0]                   byte_nxt;
  logic [7:0]                   data_r;
  logic                         last_r;
  logic                         valid_r, valid_nxt;
  logic [15:0]                  len;

  assign len      = smf_pkg::frame_len(ctl.kind);
  assign out_free = ~valid_r | out_ready;

  // Byte source
  always_comb begin
    unique case (ctl.sel)
      smf_pkg::SEL_START:   byte_nxt = smf_pkg::START_BYTE;
      smf_pkg::SEL_ID:      byte_nxt = smf_pkg::kind_id(ctl.kind);
      smf_pkg::SEL_LEN_HI:  byte_nxt = len[15:8];
      smf_pkg::SEL_LEN_LO:  byte_nxt = len[7:0];
      smf_pkg::SEL_PAYLOAD: byte_nxt = msg_r[7:0];
      smf_pkg::SEL_STATUS:  byte_nxt = status_r;
      smf_pkg::SEL_SUM:     byte_nxt = sum_r;
      default:              byte_nxt = sum_r;
    endcase
  end

  // Message store and checksum; words go out low byte first
  always_ff @(posedge clk) begin
    if (load) begin
      msg_r    <= load_words;
      status_r <= load_status;
      sum_r    <= '0;
    end else if (ctl.emit) begin
      sum_r <= sum_r + byte_nxt;
      if (ctl.sel == smf_pkg::SEL_PAYLOAD) begin
        msg_r <= {8'h00, msg_r[smf_pkg::MSG_BITS-1:8]};
      end
    end
  end

  // Output register
  always_comb begin
    valid_nxt = valid_r;
    if (ctl.emit) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      data_r <= byte_nxt;
      last_r <= ctl.last;
    end
  end

  assign out_valid = valid_r;
  assign out_byte  = data_r;
  assign out_last  = last_r;

endmodule

`default_nettype wire
